// ===== hw/rtl/pvrg_pkg.sv =====
// Shared types and constants for the pooled vector random generator.
// Holds the controller state type, the command and status structs and the pool geometry.
// No dependencies.
package pvrg_pkg;

	// data and pool geometry
	localparam int WORD_W        = 32;
	localparam int LANE_W        = 2 * WORD_W;
	localparam int POOL_DEPTH    = 64;
	localparam int POOL_AW       = 6;
	localparam int SCRATCH_DEPTH = 32;
	localparam int SCRATCH_AW    = 5;
	localparam int VEC_WORDS     = 8;
	localparam int VEC_COUNT     = 8;
	localparam int SRC_VECS      = 4;
	localparam int LANES         = 4;
	localparam int CNT_W         = 6;
	localparam int WL_W          = 7;

	// refill scheme: word rotation and lane shift for even and odd source vectors
	localparam int ROT_EVEN = 5;
	localparam int ROT_ODD  = 3;
	localparam int SHR_EVEN = 1;
	localparam int SHR_ODD  = 3;

	// step counter end points
	localparam logic [CNT_W-1:0] LOAD_LAST  = 6'd32;
	localparam logic [CNT_W-1:0] WRITE_LAST = 6'd63;
	localparam logic [CNT_W-1:0] DIV_LAST   = 6'd31;

	localparam logic [WL_W-1:0] WL_FULL = 7'd64;

	// command codes
	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_SEED = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOAD,
		ST_WRITE,
		ST_READ,
		ST_LATCH,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take_in;
		logic seed_wr;
		logic cnt_clr;
		logic cnt_inc;
		logic load_rd;
		logic refill_wr;
		logic draw_rd;
		logic div_load;
		logic div_step;
		logic res_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic cmd_seed;
		logic mod_zero;
		logic wl_zero;
		logic load_last;
		logic write_last;
		logic div_last;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/pvrg_div.sv =====
// Restoring serial remainder unit, one quotient bit per step.
// Depends on pvrg_pkg for the word width.
module pvrg_div (
	input  logic                         clk,
	input  logic                         load,
	input  logic                         step,
	input  logic [pvrg_pkg::WORD_W-1:0]  dividend,
	input  logic [pvrg_pkg::WORD_W-1:0]  divisor,
	output logic [pvrg_pkg::WORD_W-1:0]  remainder
);

	logic [pvrg_pkg::WORD_W-1:0] rem_q;
	logic [pvrg_pkg::WORD_W-1:0] dvd_q;
	logic [pvrg_pkg::WORD_W:0]   trial;
	logic [pvrg_pkg::WORD_W:0]   diff;
	logic                        fits;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, dvd_q[pvrg_pkg::WORD_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	// remainder and dividend shift registers
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (step) begin
			rem_q <= fits ? diff[pvrg_pkg::WORD_W-1:0] : trial[pvrg_pkg::WORD_W-1:0];
			dvd_q <= {dvd_q[pvrg_pkg::WORD_W-2:0], 1'b0};
		end
	end

	assign remainder = rem_q;

endmodule

// ===== hw/rtl/pvrg_dpath.sv =====
// Datapath: pool memory with valid bits, scratch copy for refill, refill arithmetic,
// words-left count, step counter, remainder unit and result register.
// Depends on pvrg_pkg and pvrg_div.
module pvrg_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pvrg_pkg::ctl_cmd_t                  cmd,
	output pvrg_pkg::ctl_sts_t                  sts,
	input  logic                                command,
	input  logic [pvrg_pkg::POOL_AW-1:0]        seed_index,
	input  logic [pvrg_pkg::WORD_W-1:0]         seed_word,
	input  logic [pvrg_pkg::WORD_W-1:0]         modulus,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pvrg_pkg::WORD_W-1:0]         value,
	output logic                                modulus_error
);

	// captured transaction
	logic                              cmd_q;
	logic [pvrg_pkg::POOL_AW-1:0]      idx_q;
	logic [pvrg_pkg::WORD_W-1:0]       seedw_q;
	logic [pvrg_pkg::WORD_W-1:0]       mod_q;

	// control registers
	logic [pvrg_pkg::CNT_W-1:0]        cnt_q;
	logic [pvrg_pkg::WL_W-1:0]         wl_q;
	logic [pvrg_pkg::WL_W-1:0]         wl_dec;
	logic [pvrg_pkg::POOL_DEPTH-1:0]   valid_q;
	logic                              out_valid_q;
	logic [pvrg_pkg::WORD_W-1:0]       value_q;
	logic                              err_q;

	// pool memory and its read stage
	logic [pvrg_pkg::WORD_W-1:0]       mem [pvrg_pkg::POOL_DEPTH];
	logic [pvrg_pkg::WORD_W-1:0]       rd_data_s1;
	logic                              rd_valid_s1;
	logic                              cap_s1;
	logic [pvrg_pkg::SCRATCH_AW-1:0]   cap_idx_s1;
	logic [pvrg_pkg::WORD_W-1:0]       rd_word;
	logic                              load_issue;
	logic                              mem_re;
	logic                              mem_we;
	logic [pvrg_pkg::POOL_AW-1:0]      rd_addr;
	logic [pvrg_pkg::POOL_AW-1:0]      wr_addr;
	logic [pvrg_pkg::WORD_W-1:0]       wr_data;

	// refill working set
	logic [pvrg_pkg::WORD_W-1:0]       scratch_q [pvrg_pkg::SCRATCH_DEPTH];
	logic [pvrg_pkg::LANE_W-1:0]       u_lane   [pvrg_pkg::SRC_VECS][pvrg_pkg::LANES];
	logic [pvrg_pkg::LANE_W-1:0]       t_lane   [pvrg_pkg::SRC_VECS][pvrg_pkg::LANES];
	logic [pvrg_pkg::LANE_W-1:0]       n_lane   [pvrg_pkg::SRC_VECS][pvrg_pkg::LANES];
	logic [pvrg_pkg::LANE_W-1:0]       vec_lane [pvrg_pkg::VEC_COUNT][pvrg_pkg::LANES];
	logic [pvrg_pkg::WORD_W-1:0]       new_word [pvrg_pkg::POOL_DEPTH];

	logic [pvrg_pkg::WORD_W-1:0]       remainder;
	logic                              is_seed;
	logic                              is_zero;

	// transaction capture
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			cmd_q   <= command;
			idx_q   <= seed_index;
			seedw_q <= seed_word;
			mod_q   <= modulus;
		end
	end

	assign is_seed = (cmd_q == pvrg_pkg::CMD_SEED);
	assign is_zero = (mod_q == '0);
	assign wl_dec  = wl_q - pvrg_pkg::WL_W'(1);

	// step counter and words-left count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wl_q  <= pvrg_pkg::WL_FULL;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + pvrg_pkg::CNT_W'(1);
			end
			if (cmd.seed_wr || cmd.refill_wr) begin
				wl_q <= pvrg_pkg::WL_FULL;
			end else if (cmd.draw_rd) begin
				wl_q <= wl_dec;
			end
		end
	end

	// memory port selection
	always_comb begin
		load_issue = cmd.load_rd && (cnt_q != pvrg_pkg::LOAD_LAST);
		mem_re     = load_issue || cmd.draw_rd;
		rd_addr    = cmd.draw_rd ? wl_dec[pvrg_pkg::POOL_AW-1:0]
			: pvrg_pkg::POOL_AW'(cnt_q[pvrg_pkg::SCRATCH_AW-1:0]);
		mem_we     = cmd.seed_wr || cmd.refill_wr;
		wr_addr    = cmd.seed_wr ? idx_q : cnt_q;
		wr_data    = cmd.seed_wr ? seedw_q : new_word[cnt_q];
	end

	// pool memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// valid bits stand for the zero reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			cap_s1      <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (mem_re) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
			cap_s1 <= load_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (load_issue) begin
			cap_idx_s1 <= cnt_q[pvrg_pkg::SCRATCH_AW-1:0];
		end
	end

	assign rd_word = rd_valid_s1 ? rd_data_s1 : '0;

	// scratch copy of source vectors 0..3
	always_ff @(posedge clk) begin
		if (cap_s1) begin
			scratch_q[cap_idx_s1] <= rd_word;
		end
	end

	// per lane shift, rotate and add of the source vectors
	for (genvar ga = 0; ga < pvrg_pkg::SRC_VECS; ga++) begin : g_src
		localparam int ROT  = (ga % 2 == 1) ? pvrg_pkg::ROT_ODD : pvrg_pkg::ROT_EVEN;
		localparam int SHR  = (ga % 2 == 1) ? pvrg_pkg::SHR_ODD : pvrg_pkg::SHR_EVEN;
		localparam int BASE = pvrg_pkg::VEC_WORDS * ga;
		for (genvar gk = 0; gk < pvrg_pkg::LANES; gk++) begin : g_lane
			localparam int LO  = BASE + 2 * gk;
			localparam int TLO = BASE + (2 * gk + ROT) % pvrg_pkg::VEC_WORDS;
			localparam int THI = BASE + (2 * gk + 1 + ROT) % pvrg_pkg::VEC_WORDS;
			assign u_lane[ga][gk] = {scratch_q[LO + 1], scratch_q[LO]} >> SHR;
			assign t_lane[ga][gk] = {scratch_q[THI], scratch_q[TLO]};
			assign n_lane[ga][gk] = t_lane[ga][gk] + u_lane[ga][gk];
		end
	end

	// new vectors: sums first, then the xor mixes
	for (genvar gk = 0; gk < pvrg_pkg::LANES; gk++) begin : g_mix
		assign vec_lane[0][gk] = n_lane[0][gk];
		assign vec_lane[1][gk] = n_lane[1][gk];
		assign vec_lane[2][gk] = n_lane[2][gk];
		assign vec_lane[3][gk] = n_lane[3][gk];
		assign vec_lane[4][gk] = u_lane[0][gk] ^ t_lane[1][gk];
		assign vec_lane[5][gk] = u_lane[2][gk] ^ t_lane[3][gk];
		assign vec_lane[6][gk] = n_lane[0][gk] ^ n_lane[3][gk];
		assign vec_lane[7][gk] = n_lane[2][gk] ^ n_lane[1][gk];
	end

	// split lanes back into pool words
	for (genvar gv = 0; gv < pvrg_pkg::VEC_COUNT; gv++) begin : g_vec
		for (genvar gi = 0; gi < pvrg_pkg::VEC_WORDS; gi++) begin : g_word
			assign new_word[pvrg_pkg::VEC_WORDS * gv + gi] =
				vec_lane[gv][gi / 2][pvrg_pkg::WORD_W * (gi % 2) +: pvrg_pkg::WORD_W];
		end
	end

	// remainder of the drawn word
	pvrg_div u_div (
		.clk       (clk),
		.load      (cmd.div_load),
		.step      (cmd.div_step),
		.dividend  (rd_word),
		.divisor   (mod_q),
		.remainder (remainder)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			value_q <= (is_seed || is_zero) ? '0 : remainder;
			err_q   <= !is_seed && is_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign value         = value_q;
	assign modulus_error = err_q;

	// status to the controller
	always_comb begin
		sts.cmd_seed   = is_seed;
		sts.mod_zero   = is_zero;
		sts.wl_zero    = (wl_q == '0);
		sts.load_last  = (cnt_q == pvrg_pkg::LOAD_LAST);
		sts.write_last = (cnt_q == pvrg_pkg::WRITE_LAST);
		sts.div_last   = (cnt_q == pvrg_pkg::DIV_LAST);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// a draw never reads from an empty pool
	a_draw_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_rd |-> (wl_q != '0))
		else $error("pool read with no words left");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// a finished refill leaves a full, fully written pool
	a_refill_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.refill_wr && (cnt_q == pvrg_pkg::WRITE_LAST)) |=>
			((wl_q == pvrg_pkg::WL_FULL) && (&valid_q)))
		else $error("refill did not leave a full pool");

	// each divider step keeps the partial remainder below the bound
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (remainder < mod_q))
		else $error("partial remainder not below modulus");

endmodule

// ===== hw/rtl/pvrg_ctrl.sv =====
// Controller state machine: sequences decode, pool refill, pool read,
// serial remainder and result hand-off. Depends on pvrg_pkg.
module pvrg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pvrg_pkg::ctl_sts_t  sts,
	output pvrg_pkg::ctl_cmd_t  cmd
);

	pvrg_pkg::state_t state_q;
	pvrg_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvrg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = (state_q != pvrg_pkg::ST_IDLE);
		case (state_q)
			pvrg_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_nxt   = pvrg_pkg::ST_DECODE;
				end
			end
			pvrg_pkg::ST_DECODE: begin
				if (sts.cmd_seed) begin
					cmd.seed_wr = 1'b1;
					state_nxt   = pvrg_pkg::ST_DONE;
				end else if (sts.mod_zero) begin
					state_nxt = pvrg_pkg::ST_DONE;
				end else if (sts.wl_zero) begin
					cmd.cnt_clr = 1'b1;
					state_nxt   = pvrg_pkg::ST_LOAD;
				end else begin
					state_nxt = pvrg_pkg::ST_READ;
				end
			end
			// copy source vectors into the scratch set
			pvrg_pkg::ST_LOAD: begin
				cmd.load_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.load_last) begin
					cmd.cnt_clr = 1'b1;
					state_nxt   = pvrg_pkg::ST_WRITE;
				end
			end
			// write back all new pool words
			pvrg_pkg::ST_WRITE: begin
				cmd.refill_wr = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (sts.write_last) begin
					cmd.cnt_clr = 1'b1;
					state_nxt   = pvrg_pkg::ST_READ;
				end
			end
			pvrg_pkg::ST_READ: begin
				cmd.draw_rd = 1'b1;
				state_nxt   = pvrg_pkg::ST_LATCH;
			end
			pvrg_pkg::ST_LATCH: begin
				cmd.div_load = 1'b1;
				cmd.cnt_clr  = 1'b1;
				state_nxt    = pvrg_pkg::ST_DIV;
			end
			pvrg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (sts.div_last) begin
					state_nxt = pvrg_pkg::ST_DONE;
				end
			end
			pvrg_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = pvrg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pvrg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/pooled_vector_random_generator_unit.sv =====
// Pooled vector random generator, one transaction at a time.
// Draw: one pool word is read and reduced by the 32-step serial remainder; the next
// transaction is taken once the result is handed off. A draw that finds the pool empty
// first refills it (32 scratch reads, then 64 writes through the single memory write port).
// Seed writes one pool word; seed and zero modulus skip the pool read and the remainder.
// Reset: pool reads as zero until written, 64 words left, no result pending.
module pooled_vector_random_generator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [pvrg_pkg::POOL_AW-1:0] seed_index,
	input  logic [pvrg_pkg::WORD_W-1:0]  seed_word,
	input  logic [pvrg_pkg::WORD_W-1:0]  modulus,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pvrg_pkg::WORD_W-1:0]  value,
	output logic                         modulus_error
);

	pvrg_pkg::ctl_cmd_t cmd;
	pvrg_pkg::ctl_sts_t sts;

	// sequencing
	pvrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pool, refill arithmetic and remainder
	pvrg_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.command       (command),
		.seed_index    (seed_index),
		.seed_word     (seed_word),
		.modulus       (modulus),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.modulus_error (modulus_error)
	);

endmodule
